### sv/wwps_pkg.sv
package wwps_pkg;

  localparam int unsigned DAY_W       = 3;
  localparam int unsigned MIN_W       = 11;
  localparam int unsigned NUM_DAYS    = 7;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 30;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [DAY_W-1:0] DAY_INVALID = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_BASE  = 3'd1;

  // packed as in the profile register, enable at the top
  typedef struct packed {
    logic                enable;
    logic [NUM_DAYS-1:0] days;
    logic [MIN_W-1:0]    end_min;
    logic [MIN_W-1:0]    open_min;
  } profile_t;

  typedef struct packed {
    logic [IDX_W-1:0] profile_index;
    logic             matched;
  } result_t;

endpackage

### sv/weekly_window_profile_select.sv
// channel     dir  handshake                     payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata: weekday[2:0], now_min[13:3]
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata: matched[0], profile_index[3:1]
// cfg         in   cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// one request per cycle while the output is taken; three register stages, so a
// request passes stage 1, stage 2 and the output register before m_axis_tvalid rises
// stages: day decode, parallel window compare of all profiles, priority pick
// one shared stall enable moves all stages; ready drops only while the
// output register holds a result that is not taken
// reset clears all valid bits and the profile registers
module weekly_window_profile_select #(
  parameter int unsigned MAX_PROFILES = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wwps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wwps_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // weekday[2:0], now_min[13:3], zeros above
  input  logic [wwps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // matched[0], profile_index[3:1], zeros above
  output logic [wwps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import wwps_pkg::*;

  logic [COUNT_W-1:0] count_q;
  profile_t           profile_q [MAX_PROFILES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < int'(MAX_PROFILES); i++) begin
        profile_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PROFILE_COUNT) begin
        count_q <= cfg_wdata_i[COUNT_W-1:0];
      end
      for (int i = 0; i < int'(MAX_PROFILES); i++) begin
        if (cfg_idx_i == CFG_IDX_W'(int'(CFG_PROFILE_BASE) + i)) begin
          profile_q[i] <= profile_t'(cfg_wdata_i);
        end
      end
    end
  end

  // profiles in use; a count above the profile number covers all of them
  logic [MAX_PROFILES-1:0] in_use;
  always_comb begin
    for (int i = 0; i < int'(MAX_PROFILES); i++) begin
      in_use[i] = (32'(i) < 32'(count_q));
    end
  end

  logic adv;
  logic m_valid_q;
  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: day decode
  logic [DAY_W-1:0]    in_day;
  logic [MIN_W-1:0]    in_now;
  logic [NUM_DAYS-1:0] today_d;
  assign in_day = s_axis_tdata[DAY_W-1:0];
  assign in_now = s_axis_tdata[DAY_W+MIN_W-1:DAY_W];

  always_comb begin
    today_d = '0;
    if (in_day != DAY_INVALID) begin
      today_d[in_day] = 1'b1;
    end
  end

  logic                s1_valid_q;
  logic [MIN_W-1:0]    s1_now_q;
  logic [NUM_DAYS-1:0] s1_today_q;
  logic [NUM_DAYS-1:0] s1_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      s1_now_q   <= in_now;
      s1_today_q <= today_d;
      s1_prev_q  <= {today_d[0], today_d[NUM_DAYS-1:1]};
    end
  end

  // stage 2: window compare, all profiles side by side
  logic [MAX_PROFILES-1:0] hit_d;
  always_comb begin
    for (int i = 0; i < int'(MAX_PROFILES); i++) begin
      logic on_today;
      logic on_prev;
      logic after_start;
      logic before_end;
      on_today    = |(profile_q[i].days & s1_today_q);
      on_prev     = |(profile_q[i].days & s1_prev_q);
      after_start = (s1_now_q >= profile_q[i].open_min);
      before_end  = (s1_now_q < profile_q[i].end_min);
      if (!profile_q[i].enable || !in_use[i] ||
          profile_q[i].open_min == profile_q[i].end_min) begin
        hit_d[i] = 1'b0;
      end else if (profile_q[i].open_min < profile_q[i].end_min) begin
        hit_d[i] = on_today && after_start && before_end;
      end else begin
        hit_d[i] = (after_start && on_today) || (before_end && on_prev);
      end
    end
  end

  logic                    s2_valid_q;
  logic [MAX_PROFILES-1:0] s2_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_hit_q <= hit_d;
    end
  end

  // stage 3: lowest index wins
  result_t res_d;
  always_comb begin
    res_d = '0;
    for (int i = int'(MAX_PROFILES) - 1; i >= 0; i--) begin
      if (s2_hit_q[i]) begin
        res_d.matched       = 1'b1;
        res_d.profile_index = IDX_W'(i);
      end
    end
  end

  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(res_q);

endmodule

### sv/wwps_checker.sv
module wwps_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [wwps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wwps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import wwps_pkg::*;

  // no match reports index zero, a match never reports index seven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] ? (m_axis_tdata[3:1] != 3'd7)
                                       : (m_axis_tdata[3:1] == 3'd0)))
    else $error("bad result encoding");

  // an invalid weekday request, with the output taken as it moves through the stages, comes out as no match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[DAY_W-1:0] == DAY_INVALID)
      ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("invalid weekday matched");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind weekly_window_profile_select wwps_checker u_wwps_checker (.*);
